@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the radar target frame parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RTFP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `RTFP_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define RTFP_ASSERT(lbl, clk, rstn, prop, msg)
`define RTFP_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ rtl/core/rtfp_pkg.sv @@
// Package for the radar target frame parser: constants, state types, structs.
// No dependencies; used by every module of the block but rtfp_ram.
`default_nettype none

package rtfp_pkg;

  // frame format
  localparam logic [7:0] HDR_B0 = 8'hAA;
  localparam logic [7:0] HDR_B1 = 8'hFF;
  localparam logic [7:0] HDR_B2 = 8'h03;
  localparam logic [7:0] HDR_B3 = 8'h00;
  localparam logic [7:0] FOOT_B0 = 8'h55;
  localparam logic [7:0] FOOT_B1 = 8'hCC;

  localparam int FRAME_BYTES  = 30;
  localparam int BODY_BYTES   = FRAME_BYTES - 4;
  localparam int BODY_AW      = $clog2(BODY_BYTES);
  localparam int REC_BYTES    = 8;
  localparam int FOOT_BYTES   = 2;
  localparam int TARGET_SLOTS = 3;
  localparam logic [BODY_AW-1:0] FOOT_ADDR = BODY_AW'(TARGET_SLOTS * REC_BYTES);

  localparam logic [15:0] RANGE_RESET = 16'd10000;

  typedef enum logic [2:0] {
    HUNT_H0,
    HUNT_H1,
    HUNT_H2,
    HUNT_H3,
    HUNT_BODY
  } hunt_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_FOOT,
    SQ_LIM,
    SQ_LIM_W,
    SQ_REC,
    SQ_SQX,
    SQ_SQY,
    SQ_SUM_W,
    SQ_EMIT,
    SQ_BAD
  } seq_state_t;

  typedef enum logic [1:0] {
    SQR_NONE,
    SQR_LOAD,
    SQR_ADD
  } sqr_op_t;

  typedef struct packed {
    logic               en;
    logic [BODY_AW-1:0] addr;
    logic [7:0]         data;
  } mem_wr_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] acc;
  } sqr_stat_t;

  // sign-magnitude word, MSB set = positive
  function automatic logic [15:0] sm_decode(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? mag : (~mag + 16'd1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rtfp_ram.sv @@
// Body byte store: one write port, one registered read port.
// Depends on nothing; sized by its parameters.
`default_nettype none

module rtfp_ram #(
  parameter int DEPTH = 26,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rtfp_hunt.sv @@
// Header hunt and body capture: finds AA FF 03 00, writes the body bytes.
// Depends on rtfp_pkg.
`default_nettype none

module rtfp_hunt (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_vld,
  input  wire logic [7:0]       byte_data,
  output rtfp_pkg::mem_wr_t     wr,
  output logic                  frame_done
);

  localparam logic [rtfp_pkg::BODY_AW-1:0] POS_LAST =
    rtfp_pkg::BODY_AW'(rtfp_pkg::BODY_BYTES - 1);

  rtfp_pkg::hunt_state_t state_r, state_nxt;
  logic [rtfp_pkg::BODY_AW-1:0] pos_r, pos_nxt;
  logic done_r, done_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (byte_vld) begin
      unique case (state_r)
        rtfp_pkg::HUNT_H0: begin
          state_nxt = (byte_data == rtfp_pkg::HDR_B0) ? rtfp_pkg::HUNT_H1 : rtfp_pkg::HUNT_H0;
        end
        rtfp_pkg::HUNT_H1: begin
          if (byte_data == rtfp_pkg::HDR_B1) state_nxt = rtfp_pkg::HUNT_H2;
          else if (byte_data == rtfp_pkg::HDR_B0) state_nxt = rtfp_pkg::HUNT_H1;
          else state_nxt = rtfp_pkg::HUNT_H0;
        end
        rtfp_pkg::HUNT_H2: begin
          if (byte_data == rtfp_pkg::HDR_B2) state_nxt = rtfp_pkg::HUNT_H3;
          else if (byte_data == rtfp_pkg::HDR_B0) state_nxt = rtfp_pkg::HUNT_H1;
          else state_nxt = rtfp_pkg::HUNT_H0;
        end
        rtfp_pkg::HUNT_H3: begin
          if (byte_data == rtfp_pkg::HDR_B3) state_nxt = rtfp_pkg::HUNT_BODY;
          else if (byte_data == rtfp_pkg::HDR_B0) state_nxt = rtfp_pkg::HUNT_H1;
          else state_nxt = rtfp_pkg::HUNT_H0;
        end
        rtfp_pkg::HUNT_BODY: begin
          if (pos_r == POS_LAST) state_nxt = rtfp_pkg::HUNT_H0;
        end
        default: state_nxt = rtfp_pkg::HUNT_H0;
      endcase
    end
  end

  // outputs
  always_comb begin
    wr.en    = byte_vld && (state_r == rtfp_pkg::HUNT_BODY);
    wr.addr  = pos_r;
    wr.data  = byte_data;
    done_nxt = wr.en && (pos_r == POS_LAST);
    pos_nxt  = pos_r;
    if (byte_vld) begin
      if (state_r != rtfp_pkg::HUNT_BODY || pos_r == POS_LAST) pos_nxt = '0;
      else pos_nxt = pos_r + rtfp_pkg::BODY_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtfp_pkg::HUNT_H0;
      pos_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      done_r  <= done_nxt;
    end
  end

  assign frame_done = done_r;

endmodule

`default_nettype wire

@@ rtl/core/rtfp_sqr.sv @@
// Shared squaring unit: registered 16x16 square, then load or accumulate.
// Depends on rtfp_pkg.
`default_nettype none

module rtfp_sqr (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rtfp_pkg::sqr_op_t op,
  input  wire logic [15:0]       operand,
  output rtfp_pkg::sqr_stat_t    stat
);

  rtfp_pkg::sqr_op_t op_r;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] acc_r, acc_nxt;

  assign prod_nxt = 32'(operand) * 32'(operand);

  always_comb begin
    acc_nxt = acc_r;
    unique case (op_r)
      rtfp_pkg::SQR_NONE: acc_nxt = acc_r;
      rtfp_pkg::SQR_LOAD: acc_nxt = prod_r;
      rtfp_pkg::SQR_ADD:  acc_nxt = acc_r + prod_r;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= rtfp_pkg::SQR_NONE;
    end else begin
      op_r <= op;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign stat.busy = (op_r != rtfp_pkg::SQR_NONE);
  assign stat.acc  = acc_r;

endmodule

`default_nettype wire

@@ rtl/core/radar_target_frame_parser.sv @@
// Radar target frame parser top level: frame sequencer and result register.
// Depends on rtfp_pkg, rtfp_ram, rtfp_hunt, rtfp_sqr and assert_macros.svh.
//
// Usage:
//  - in_*: one received serial byte per transfer (in_tdata[7:0]). The block
//    hunts for the header AA FF 03 00 and stores the 26 body bytes.
//  - out_*: one result per transfer. A good frame (footer 55 CC) gives three
//    target results in slot order; a bad footer gives one result with
//    out_tuser = 1 and all data zero. out_tlast marks the last result of a frame.
//  - cfg_*: writes range_limit_mm (cfg_data[15:0]); cfg_ready is always high.
//    Write only while the block is idle.
//  - Throughput: one byte per cycle while hunting or storing. The final body
//    byte starts the sequencer, which reads the store one byte a cycle and
//    squares x, y and the limit on one shared multiplier: footer check,
//    then the limit and each target slot in turn unless the footer is bad;
//    in_tready returns once the last result is loaded.
//  - in_tready is low while the sequencer runs. A stalled receiver holds the
//    result in the output register and freezes the sequencer; once the last
//    result is loaded, bytes are taken again while it waits to be taken.
//  - Reset (rst_n low, synchronous) returns to header hunt, empties the
//    output register and loads the range limit with 10000 mm.
`default_nettype none
`include "assert_macros.svh"

module radar_target_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [1:0] target_index, [17:2] pos_x_mm,
                                       // [33:18] pos_y_mm, [49:34] speed_cms,
                                       // [65:50] resolution_word, [66] target_active,
                                       // [68:67] active_count, [69] presence, [71:70] 0
  output logic             out_tuser,  // [0] frame_status (1 = bad footer)
  output logic             out_tlast,  // last_of_frame
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // range_limit_mm
);

  localparam int CNT_LSB = 67;
  localparam logic [3:0] FETCH_FOOT = 4'(rtfp_pkg::FOOT_BYTES);
  localparam logic [3:0] FETCH_REC  = 4'(rtfp_pkg::REC_BYTES);
  localparam logic [1:0] SLOT_LAST  = 2'(rtfp_pkg::TARGET_SLOTS - 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [15:0] lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= rtfp_pkg::RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lim_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Header hunt and body store
  // ---------------------------------------------------------------------------
  rtfp_pkg::seq_state_t state_r, state_nxt;
  rtfp_pkg::mem_wr_t    wr;
  logic                 frame_done;
  logic                 in_xfer;

  logic                             rd_en;
  logic [rtfp_pkg::BODY_AW-1:0]     rd_addr;
  logic [7:0]                       rd_data;

  // a frame's body is complete once frame_done fires; hold off the next byte
  assign in_tready = (state_r == rtfp_pkg::SQ_IDLE) && !frame_done;
  assign in_xfer   = in_tvalid && in_tready;

  rtfp_hunt u_hunt (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (in_xfer),
    .byte_data  (in_tdata),
    .wr         (wr),
    .frame_done (frame_done)
  );

  rtfp_ram #(
    .DEPTH (rtfp_pkg::BODY_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Shared squaring unit
  // ---------------------------------------------------------------------------
  rtfp_pkg::sqr_op_t   sqr_op;
  logic [15:0]         sqr_operand;
  rtfp_pkg::sqr_stat_t sqr_stat;

  rtfp_sqr u_sqr (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (sqr_op),
    .operand (sqr_operand),
    .stat    (sqr_stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer datapath
  // ---------------------------------------------------------------------------
  logic [3:0]  cnt_r, cnt_nxt;
  logic        pend_r;
  logic [63:0] rec_r;        // fetched bytes, first byte in the low bits
  logic [31:0] lim2_r;
  logic [1:0]  slot_r, slot_nxt;
  logic [1:0]  tally_r, tally_nxt;

  logic        fetching;
  logic [3:0]  fetch_len;
  logic        fetch_done;
  logic [rtfp_pkg::BODY_AW-1:0] base;
  logic        foot_ok;
  logic        out_free;
  logic        last_slot;
  logic        act;
  logic        push_good;
  logic        push_bad;
  logic        lim_cap;

  assign fetching   = (state_r == rtfp_pkg::SQ_FOOT) || (state_r == rtfp_pkg::SQ_REC);
  assign fetch_len  = (state_r == rtfp_pkg::SQ_FOOT) ? FETCH_FOOT : FETCH_REC;
  assign fetch_done = fetching && (cnt_r == fetch_len) && !pend_r;
  assign base       = (state_r == rtfp_pkg::SQ_FOOT) ? rtfp_pkg::FOOT_ADDR
                                                     : {slot_r, 3'b000};
  assign rd_addr    = base + rtfp_pkg::BODY_AW'(cnt_r[2:0]);

  // footer bytes land in the top two bytes after a two-byte fetch
  assign foot_ok   = (rec_r[55:48] == rtfp_pkg::FOOT_B0) &&
                     (rec_r[63:56] == rtfp_pkg::FOOT_B1);
  assign out_free  = !out_tvalid || out_tready;
  assign last_slot = (slot_r == SLOT_LAST);

  // any raw word nonzero and x^2 + y^2 below limit^2
  assign act = (rec_r != 64'd0) && (sqr_stat.acc < lim2_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtfp_pkg::SQ_IDLE:  if (frame_done) state_nxt = rtfp_pkg::SQ_FOOT;
      rtfp_pkg::SQ_FOOT: begin
        if (fetch_done) state_nxt = foot_ok ? rtfp_pkg::SQ_LIM : rtfp_pkg::SQ_BAD;
      end
      rtfp_pkg::SQ_LIM:   state_nxt = rtfp_pkg::SQ_LIM_W;
      rtfp_pkg::SQ_LIM_W: if (!sqr_stat.busy) state_nxt = rtfp_pkg::SQ_REC;
      rtfp_pkg::SQ_REC:   if (fetch_done) state_nxt = rtfp_pkg::SQ_SQX;
      rtfp_pkg::SQ_SQX:   state_nxt = rtfp_pkg::SQ_SQY;
      rtfp_pkg::SQ_SQY:   state_nxt = rtfp_pkg::SQ_SUM_W;
      rtfp_pkg::SQ_SUM_W: if (!sqr_stat.busy) state_nxt = rtfp_pkg::SQ_EMIT;
      rtfp_pkg::SQ_EMIT: begin
        if (out_free) state_nxt = last_slot ? rtfp_pkg::SQ_IDLE : rtfp_pkg::SQ_REC;
      end
      rtfp_pkg::SQ_BAD:   if (out_free) state_nxt = rtfp_pkg::SQ_IDLE;
      default:            state_nxt = rtfp_pkg::SQ_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    rd_en       = fetching && (cnt_r != fetch_len);
    sqr_op      = rtfp_pkg::SQR_NONE;
    sqr_operand = '0;
    push_good   = 1'b0;
    push_bad    = 1'b0;
    lim_cap     = 1'b0;
    unique case (state_r)
      rtfp_pkg::SQ_LIM: begin
        sqr_op      = rtfp_pkg::SQR_LOAD;
        sqr_operand = lim_r;
      end
      rtfp_pkg::SQ_LIM_W: lim_cap = !sqr_stat.busy;
      rtfp_pkg::SQ_SQX: begin
        sqr_op      = rtfp_pkg::SQR_LOAD;
        sqr_operand = {1'b0, rec_r[14:0]};
      end
      rtfp_pkg::SQ_SQY: begin
        sqr_op      = rtfp_pkg::SQR_ADD;
        sqr_operand = {1'b0, rec_r[30:16]};
      end
      rtfp_pkg::SQ_EMIT: push_good = out_free;
      rtfp_pkg::SQ_BAD:  push_bad  = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    if (fetching) cnt_nxt = rd_en ? (cnt_r + 4'd1) : cnt_r;
    slot_nxt  = slot_r;
    tally_nxt = tally_r;
    if (state_r == rtfp_pkg::SQ_IDLE) begin
      slot_nxt  = '0;
      tally_nxt = '0;
    end else if (push_good) begin
      tally_nxt = tally_r + 2'(act);
      slot_nxt  = last_slot ? 2'd0 : (slot_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtfp_pkg::SQ_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      slot_r  <= '0;
      tally_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= rd_en;
      slot_r  <= slot_nxt;
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      rec_r <= {rd_data, rec_r[63:8]};
    end
    if (lim_cap) begin
      lim2_r <= sqr_stat.acc;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic        out_user_r;
  logic        out_last_r;
  logic [1:0]  count_fld;
  logic        pres_fld;

  assign count_fld = last_slot ? tally_nxt : 2'd0;
  assign pres_fld  = last_slot && (tally_nxt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_good || push_bad) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_good) begin
      out_data_r <= {2'b00, pres_fld, count_fld, act, rec_r[63:48],
                     rtfp_pkg::sm_decode(rec_r[47:32]),
                     rtfp_pkg::sm_decode(rec_r[31:16]),
                     rtfp_pkg::sm_decode(rec_r[15:0]),
                     slot_r};
      out_user_r <= 1'b0;
      out_last_r <= last_slot;
    end else if (push_bad) begin
      out_data_r <= '0;
      out_user_r <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RTFP_ASSERT(a_bad_is_last, clk, rst_n, out_tvalid && out_tuser |-> out_tlast, "bad footer result not last")
  `RTFP_ASSERT(a_bad_zero, clk, rst_n, out_tvalid && out_tuser |-> out_tdata == 72'd0, "bad footer result carries data")
  `RTFP_ASSERT_NEVER(a_tally_early, clk, rst_n, out_tvalid && !out_tlast && out_tdata[CNT_LSB+2:CNT_LSB] != 3'd0, "frame totals before last result")
  `RTFP_ASSERT(a_done_starts, clk, rst_n, frame_done |=> state_r == rtfp_pkg::SQ_FOOT, "frame end did not start sequencer")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for radar_target_frame_parser: byte stream in, target results out.
// Depends on rtfp_pkg; decoder or hand-typed rows predict results for its scoreboard.
module tb;
  import rtfp_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;  // watchdog, many times the slowest run
  localparam int          SETTLE      = 80;      // outlasts a sequencer run
  localparam int          LONG_HOLD   = 400;     // receiver hold-off, several frames long
  localparam int          N_DIR_ROWS  = 7;
  localparam logic [15:0] GOOD_FOOT   = {FOOT_B1, FOOT_B0};  // first footer byte low

  // How a directed row gets its expectation: from the decoder, or typed in by hand.
  typedef enum logic [1:0] {
    PIN_PREDICT,
    PIN_BAD_FOOTER,
    PIN_QUIET
  } pin_kind_t;

  // One directed frame: optional lead-in bytes (first byte lowest), three target
  // records (slot 0 lowest, each {res, speed, y, x}) and the footer.
  typedef struct packed {
    pin_kind_t    pin;
    logic [3:0]   lead_len;
    logic [63:0]  lead;
    logic [191:0] words;
    logic [15:0]  foot;
  } frame_row_t;

  // One result transfer as the decoder expects it.
  typedef struct packed {
    logic [1:0]  slot;
    logic [15:0] x_mm;
    logic [15:0] y_mm;
    logic [15:0] speed;
    logic [15:0] res_word;
    logic        active;
    logic [1:0]  n_active;
    logic        presence;
    logic        bad_footer;
    logic        last;
  } target_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  always #5 clk = ~clk;

  radar_target_frame_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  logic [7:0]     rx_bytes_q[$];          // bytes waiting to be offered
  target_result_t expected_targets[$];    // results owed by the block, oldest first
  int             mismatches     = 0;
  int             bytes_queued   = 0;
  int             cycle_count    = 0;
  logic           hold_req       = 1'b0;  // asks the receiver for one long hold-off
  logic           pin_next_frame = 1'b0;  // next frame's results were typed in by hand

  // Decoder copy of the block state. Hunt states reuse the package enum.
  hunt_state_t hunt      = HUNT_H0;
  int          body_pos  = 0;
  logic [7:0]  rx_body [BODY_BYTES];
  logic [15:0] limit_mm  = RANGE_RESET;

  // ---------------------------------------------------------------------------
  // Frame decoder
  // ---------------------------------------------------------------------------
  // MSB set means positive; magnitude is the low 15 bits. 0x8000 lands on zero.
  function automatic logic [15:0] twos_from_signmag(input logic [15:0] raw);
    int mag;
    mag = int'(raw[14:0]);
    return raw[15] ? 16'(mag) : 16'(-mag);
  endfunction

  // Runs when the last body byte has been taken: queue up the frame's results.
  task automatic decode_frame();
    target_result_t   frame_q[$];
    target_result_t   t;
    logic [15:0]      w [4];
    longint unsigned  mx, my, lim, lim2;
    int               base, tally;
    lim  = limit_mm;
    lim2 = lim * lim;
    if (rx_body[int'(FOOT_ADDR)] != FOOT_B0 || rx_body[int'(FOOT_ADDR) + 1] != FOOT_B1) begin
      // bad footer: one result, everything zero but the status and last flags
      t = '0;
      t.bad_footer = 1'b1;
      t.last = 1'b1;
      frame_q.push_back(t);
    end else begin
      tally = 0;
      for (int s = 0; s < TARGET_SLOTS; s++) begin
        base = s * REC_BYTES;
        for (int k = 0; k < 4; k++) begin
          w[k] = {rx_body[base + 2*k + 1], rx_body[base + 2*k]};
        end
        t = '0;
        t.slot = 2'(s);
        t.x_mm = twos_from_signmag(w[0]);
        t.y_mm = twos_from_signmag(w[1]);
        t.speed = twos_from_signmag(w[2]);
        t.res_word = w[3];
        // exact squared-distance compare, wide enough for a 16-bit limit
        mx = w[0][14:0];
        my = w[1][14:0];
        t.active = (|{w[0], w[1], w[2], w[3]}) && (mx * mx + my * my < lim2);
        if (t.active) tally++;
        // totals only ride on the final result of the frame
        if (s == TARGET_SLOTS - 1) begin
          t.n_active = 2'(tally);
          t.presence = (tally != 0);
          t.last = 1'b1;
        end
        frame_q.push_back(t);
      end
    end
    if (pin_next_frame) begin
      pin_next_frame = 1'b0;
    end else begin
      foreach (frame_q[i]) expected_targets.push_back(frame_q[i]);
    end
  endtask

  // Advance the header hunt / body store by one accepted byte.
  task automatic take_rx_byte(input logic [7:0] b);
    logic [7:0] want;
    if (hunt == HUNT_BODY) begin
      rx_body[body_pos] = b;
      body_pos++;
      if (body_pos == BODY_BYTES) begin
        hunt = HUNT_H0;
        body_pos = 0;
        decode_frame();
      end
    end else begin
      case (hunt)
        HUNT_H0: want = HDR_B0;
        HUNT_H1: want = HDR_B1;
        HUNT_H2: want = HDR_B2;
        default: want = HDR_B3;
      endcase
      if (b == want) begin
        hunt = hunt_state_t'(hunt + 3'd1);
        body_pos = 0;
      end else if (b == HDR_B0) begin
        hunt = HUNT_H1;  // a stray AA restarts the hunt at the second byte
      end else begin
        hunt = HUNT_H0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: sample both sides at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    target_result_t want;
    if (expected_targets.size() == 0) begin
      $display("%0t: unexpected result transfer: tdata 0x%0h tuser %b tlast %b",
               $time, out_tdata, out_tuser, out_tlast);
      mismatches++;
    end else begin
      want = expected_targets.pop_front();
      check_field("target_index",    16'(want.slot),       16'(out_tdata[1:0]));
      check_field("pos_x_mm",        want.x_mm,            out_tdata[17:2]);
      check_field("pos_y_mm",        want.y_mm,            out_tdata[33:18]);
      check_field("speed_cms",       want.speed,           out_tdata[49:34]);
      check_field("resolution_word", want.res_word,        out_tdata[65:50]);
      check_field("target_active",   16'(want.active),     16'(out_tdata[66]));
      check_field("active_count",    16'(want.n_active),   16'(out_tdata[68:67]));
      check_field("presence",        16'(want.presence),   16'(out_tdata[69]));
      check_field("tdata pad",       16'd0,                16'(out_tdata[71:70]));
      check_field("frame_status",    16'(want.bad_footer), 16'(out_tuser));
      check_field("last_of_frame",   16'(want.last),       16'(out_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid && in_tready) take_rx_byte(in_tdata);
      if (out_tvalid && out_tready) check_result();
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, expected_targets.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length, random gaps. Drives at the falling edge.
  // ---------------------------------------------------------------------------
  initial begin : byte_sender
    int burst_left;
    int gap;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_bytes_q.size() == 0) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end else begin
        burst_left = $urandom_range(1, 64);
        while (burst_left > 0 && rx_bytes_q.size() != 0) begin
          in_tdata  <= rx_bytes_q[0];
          in_tvalid <= 1'b1;
          // hold the byte until the transfer happens
          do @(posedge clk); while (!in_tready);
          void'(rx_bytes_q.pop_front());
          burst_left--;
          @(negedge clk);
        end
        in_tvalid <= 1'b0;
        // always an idle gap after a burst, so valid never drops and rises in one step
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        repeat (1 + gap) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: its own stall pattern, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int mode_left;
    int period;
    int tick;
    out_tready = 1'b0;
    mode_left  = 0;
    mode       = 0;
    period     = 2;
    tick       = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          period    = $urandom_range(2, 5);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0:       out_tready <= 1'b1;                        // no stalls
          1:       out_tready <= 1'($urandom_range(0, 1));    // coin flip
          2:       out_tready <= (tick % period) != 0;        // one stall per period
          default: out_tready <= ($urandom_range(0, 7) == 0); // mostly stalled
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rec(input logic [15:0] x, y, s, r);
    return {r, s, y, x};
  endfunction

  task automatic push_rx(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  // Lead-in bytes, header, three records little-endian, footer.
  task automatic queue_frame(input logic [3:0] lead_len, input logic [63:0] lead,
                             input logic [191:0] words, input logic [15:0] foot);
    for (int i = 0; i < lead_len; i++) push_rx(lead[8*i +: 8]);
    push_rx(HDR_B0);
    push_rx(HDR_B1);
    push_rx(HDR_B2);
    push_rx(HDR_B3);
    for (int i = 0; i < 4 * TARGET_SLOTS; i++) begin
      push_rx(words[16*i +: 8]);
      push_rx(words[16*i + 8 +: 8]);
    end
    push_rx(foot[7:0]);
    push_rx(foot[15:8]);
  endtask

  // Sender pause: every byte taken and every owed result seen.
  task automatic drain();
    while (rx_bytes_q.size() != 0 || expected_targets.size() != 0) @(negedge clk);
  endtask

  // Limit writes only with the block idle; the last byte of a partial header
  // gives no result, so leave the sequencer time to settle too.
  task automatic write_range_limit(input logic [15:0] mm);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_data  <= mm;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    limit_mm = mm;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random-sign coordinate word; magnitude zero, full scale, random or near the limit.
  function automatic logic [15:0] rand_coord();
    int mag;
    case ($urandom_range(0, 5))
      0:       mag = 0;
      1:       mag = $urandom_range(0, 32767);
      2:       mag = 32767;
      3:       mag = int'(limit_mm) + $urandom_range(0, 2) - 1;
      default: mag = $urandom_range(0, 12000);
    endcase
    if (mag < 0) mag = 0;
    if (mag > 32767) mag = 32767;
    return {1'($urandom_range(0, 1)), 15'(mag)};
  endfunction

  function automatic logic [63:0] rand_rec();
    if ($urandom_range(0, 5) == 0) return 64'd0;  // empty slot
    return rec(rand_coord(), rand_coord(),
               ($urandom_range(0, 1) != 0) ? 16'($urandom) : rand_coord(),
               ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
  endfunction

  // Byte picked mostly from the header alphabet, to stress the hunt.
  function automatic logic [7:0] hunt_noise_byte();
    case ($urandom_range(0, 5))
      0:       return HDR_B0;
      1:       return HDR_B1;
      2:       return HDR_B2;
      3:       return HDR_B3;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Records listed slot 2 first, as in a concatenation.
  // ---------------------------------------------------------------------------
  function automatic frame_row_t directed_row(input int n);
    frame_row_t r;
    case (n)
      // after reset: all-zero records give three inactive results, no presence
      0:  r = '{PIN_QUIET, 4'd0, 64'd0, {3{rec(16'h0, 16'h0, 16'h0, 16'h0)}}, GOOD_FOOT};
      // bad footer: wrong second byte
      1:  r = '{PIN_BAD_FOOTER, 4'd0, 64'd0,
                {3{rec(16'h8001, 16'h8002, 16'h8003, 16'h0004)}}, {8'hCD, FOOT_B0}};
      // field extremes
      2:  r = '{PIN_PREDICT, 4'd0, 64'd0,
                {rec(16'h0001, 16'h8001, 16'h7FFF, 16'h1234),
                 rec(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000),
                 rec(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF)}, GOOD_FOOT};
      // sign-magnitude zero, and targets with only speed / resolution nonzero
      3:  r = '{PIN_PREDICT, 4'd0, 64'd0,
                {rec(16'h0000, 16'h0000, 16'h8005, 16'h0000),
                 rec(16'h0000, 16'h0000, 16'h0000, 16'h0001),
                 rec(16'h8000, 16'h8000, 16'h8000, 16'h8000)}, GOOD_FOOT};
      // right at the default limit: +10000, -9999, and a 6000/8000 hypotenuse
      4:  r = '{PIN_PREDICT, 4'd0, 64'd0,
                {rec(16'h9770, 16'h1F40, 16'h0000, 16'h0000),
                 rec(16'h270F, 16'h8000, 16'h0000, 16'h0000),
                 rec(16'hA710, 16'h8000, 16'h0000, 16'h0000)}, GOOD_FOOT};
      // header hunt: AA restart at each header position, then a non-AA fallback
      5:  r = '{PIN_PREDICT, 4'd8, 64'h55AA_FFAA_03FF_AAAA,
                {rec(16'h8000, 16'h0000, 16'h0000, 16'h0000),
                 rec(16'h0000, 16'h0000, 16'h0000, 16'h0000),
                 rec(16'h1234, 16'h9234, 16'h5555, 16'hAAAA)}, GOOD_FOOT};
      // all three active: count saturates the field
      default: r = '{PIN_PREDICT, 4'd0, 64'd0,
                {3{rec(16'h8001, 16'h8001, 16'h8001, 16'h0001)}}, GOOD_FOOT};
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    frame_row_t     row;
    target_result_t typed;
    logic [15:0]    phase_limit;
    int             frames;
    int             pick;
    int             cut;

    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 16'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows, each one drained before the next (sender pauses).
    for (int n = 0; n < N_DIR_ROWS; n++) begin
      row = directed_row(n);
      if (row.pin == PIN_BAD_FOOTER) begin
        typed = '0;
        typed.bad_footer = 1'b1;
        typed.last = 1'b1;
        expected_targets.push_back(typed);
        pin_next_frame = 1'b1;
      end else if (row.pin == PIN_QUIET) begin
        for (int s = 0; s < TARGET_SLOTS; s++) begin
          typed = '0;
          typed.slot = 2'(s);
          typed.last = (s == TARGET_SLOTS - 1);
          expected_targets.push_back(typed);
        end
        pin_next_frame = 1'b1;
      end
      queue_frame(row.lead_len, row.lead, row.words, row.foot);
      drain();
    end

    // Random phases, one limit setting each; extremes included.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       phase_limit = 16'd0;         // nothing can be active
        1:       phase_limit = 16'hFFFF;      // everything nonzero is active
        2:       phase_limit = 16'd1;
        3:       phase_limit = 16'($urandom);
        default: phase_limit = 16'($urandom_range(1000, 20000));
      endcase
      write_range_limit(phase_limit);

      // Long receiver hold-off while frames keep coming: output and input back up.
      if (p == 3) hold_req = 1'b1;

      frames = 0;
      while (frames < ((p == 3) ? 2 : 1)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          queue_frame(4'd0, 64'd0, {rand_rec(), rand_rec(), rand_rec()},
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : GOOD_FOOT);
          frames++;
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 6)) push_rx(hunt_noise_byte());
        end else begin
          // header broken off after one to three bytes
          cut = $urandom_range(1, 3);
          push_rx(HDR_B0);
          if (cut > 1) push_rx(HDR_B1);
          if (cut > 2) push_rx(HDR_B2);
          push_rx(8'($urandom));
        end
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
